// File: rtl/core/fadd_pkg.sv
// Shared types and constants for the truncating float adder/subtractor.
package fadd_pkg;

  localparam int FRAC_W = 23;
  localparam int EXP_W  = 8;
  localparam int SIG_W  = 31;  // hidden one at bit 30
  localparam int GUARD  = 7;
  localparam int MAG_W  = 25;  // magnitude after guard drop, with carry

  typedef struct packed {
    logic        op;
    logic [31:0] a_bits;
    logic [31:0] b_bits;
  } fadd_in_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        exponent_wrapped;
  } fadd_out_t;

  // Stage 1 -> 2: aligned significands
  typedef struct packed {
    logic             sa_sign;
    logic             sb_sign;
    logic [EXP_W-1:0] maxe;
    logic [SIG_W-1:0] sa;
    logic [SIG_W-1:0] sb;
  } fadd_align_t;

  // Stage 2 -> 3: magnitude after add/sub and guard drop
  typedef struct packed {
    logic             sgn;
    logic [EXP_W-1:0] maxe;
    logic [MAG_W-1:0] mag;
  } fadd_sum_t;

endpackage

// File: rtl/core/fadd_align.sv
// Stage 1: unpack operands and align significands to the larger exponent.
module fadd_align import fadd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  fadd_in_t    in_data,
  output logic        out_valid,
  output fadd_align_t out_data
);

  logic [EXP_W-1:0] ea, eb, maxe;
  logic [EXP_W-1:0] sha, shb;
  logic [SIG_W-1:0] siga, sigb;
  fadd_align_t      nxt;

  // Unpack; hidden one always present, flip b's sign on subtract
  always_comb begin
    ea   = in_data.a_bits[30:23];
    eb   = in_data.b_bits[30:23];
    maxe = (ea > eb) ? ea : eb;
    sha  = maxe - ea;
    shb  = maxe - eb;
    siga = {1'b1, in_data.a_bits[22:0], {GUARD{1'b0}}};
    sigb = {1'b1, in_data.b_bits[22:0], {GUARD{1'b0}}};
    nxt.sa_sign = in_data.a_bits[31];
    nxt.sb_sign = in_data.b_bits[31] ^ in_data.op;
    nxt.maxe    = maxe;
    nxt.sa      = (sha > EXP_W'(FRAC_W)) ? '0 : (siga >> sha);
    nxt.sb      = (shb > EXP_W'(FRAC_W)) ? '0 : (sigb >> shb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_data <= nxt;
  end

endmodule

// File: rtl/core/fadd_sum.sv
// Stage 2: signed-magnitude add or subtract, then drop guard bits.
module fadd_sum import fadd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  fadd_align_t in_data,
  output logic        out_valid,
  output fadd_sum_t   out_data
);

  logic [SIG_W:0] full;
  fadd_sum_t      nxt;

  always_comb begin
    nxt.maxe = in_data.maxe;
    if (in_data.sa_sign == in_data.sb_sign) begin
      full    = {1'b0, in_data.sa} + {1'b0, in_data.sb};
      nxt.sgn = in_data.sa_sign;
    end else if (in_data.sa > in_data.sb) begin
      full    = {1'b0, in_data.sa - in_data.sb};
      nxt.sgn = in_data.sa_sign;
    end else begin
      full    = {1'b0, in_data.sb - in_data.sa};
      nxt.sgn = in_data.sb_sign;
    end
    nxt.mag = full[SIG_W:GUARD];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_data <= nxt;
  end

endmodule

// File: rtl/core/fadd_norm.sv
// Stage 3: normalize by leading-one detect, repack and flag exponent wrap.
module fadd_norm import fadd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  fadd_sum_t in_data,
  output logic      out_valid,
  output fadd_out_t out_data
);

  logic [4:0]       lz;
  logic [MAG_W-1:0] mag;
  logic [9:0]       e;
  fadd_out_t        nxt;

  // Leading-zero count over the low 24 bits (bit 23 is the target)
  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (in_data.mag[i]) lz = 5'(23 - i);
    end
  end

  always_comb begin
    mag = in_data.mag;
    e   = {2'b00, in_data.maxe};
    if (in_data.mag[24]) begin
      mag = in_data.mag >> 1;
      e   = e + 10'd1;
    end else begin
      mag = in_data.mag << lz;
      e   = e - {5'd0, lz};
    end
    if (in_data.mag == '0) begin
      nxt = '0;
    end else begin
      nxt.result_bits      = {in_data.sgn, e[7:0], mag[22:0]};
      nxt.exponent_wrapped = e[9] | e[8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_data <= nxt;
  end

endmodule

// File: rtl/core/float_add_sub_truncating.sv
// Top level of the three-stage truncating single-precision adder/subtractor.
//
// Usage:
//   Drive operands on din and pulse start; a transfer happens at each edge
//   with start high and busy low. busy is always low, so one operation can
//   enter every cycle.
//   The result appears on dout with done high for exactly one cycle; the
//   receiver cannot stall and must take it.
//   Throughput: one item per cycle. Each item is registered in the align,
//   add/sub and normalize register stages, in that order.
//   Reset (synchronous, active high) clears the stage valid bits; items in
//   flight are dropped and no done pulse follows.
//   No rounding; infinities, NaNs and denormals get no special treatment.
//   An exponent leaving 0..255 wraps to 8 bits and sets exponent_wrapped.
module float_add_sub_truncating import fadd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  fadd_in_t  din,
  output logic      done,
  output fadd_out_t dout
);

  logic        v1, v2;
  fadd_align_t d1;
  fadd_sum_t   d2;

  assign busy = 1'b0;

  fadd_align u_align (
    .clk(clk), .rst(rst), .in_valid(start & ~busy), .in_data(din),
    .out_valid(v1), .out_data(d1)
  );

  fadd_sum u_sum (
    .clk(clk), .rst(rst), .in_valid(v1), .in_data(d1),
    .out_valid(v2), .out_data(d2)
  );

  fadd_norm u_norm (
    .clk(clk), .rst(rst), .in_valid(v2), .in_data(d2),
    .out_valid(done), .out_data(dout)
  );

endmodule

// File: sim/tb.sv
// Self-checking testbench for the truncating single-precision adder/subtractor.
module tb;
  import fadd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 3;
  localparam int STALL_LIMIT = 2000;
  localparam int N_RANDOM    = 1630;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  fadd_in_t  din;
  logic      done;
  fadd_out_t dout;

  // expected sums/differences, oldest first
  fadd_out_t sum_queue[$];
  int        error_count;
  int        idle_cycles;

  float_add_sub_truncating i_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .din  (din),
    .done (done),
    .dout (dout)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // aligns one operand's significand to the larger exponent, truncating
  function automatic logic [31:0] align_sig(logic [31:0] w, logic [7:0] maxe);
    logic [31:0] sig;
    logic [31:0] sh;
    sig = {1'b0, 1'b1, w[22:0], 7'b0};
    sh  = 32'(maxe) - 32'(w[30:23]);
    return (sh > 23) ? 32'd0 : (sig >> sh);
  endfunction

  // truncating float add/sub of one operand pair
  function automatic fadd_out_t float_sum(fadd_in_t x);
    fadd_out_t   r;
    logic        sign_a;
    logic        sign_b;
    logic [7:0]  maxe;
    logic [31:0] sa;
    logic [31:0] sb;
    logic [31:0] mag;
    logic        sgn;
    int          e;
    sign_a = x.a_bits[31];
    sign_b = x.b_bits[31] ^ (x.op == OP_SUB);
    maxe = (x.a_bits[30:23] > x.b_bits[30:23]) ? x.a_bits[30:23] : x.b_bits[30:23];
    sa = align_sig(x.a_bits, maxe);
    sb = align_sig(x.b_bits, maxe);
    if (sign_a == sign_b) begin
      mag = sa + sb;
      sgn = sign_a;
    end else if (sa > sb) begin
      mag = sa - sb;
      sgn = sign_a;
    end else begin
      mag = sb - sa;
      sgn = sign_b;
    end
    mag = mag >> 7;
    r = '0;
    if (mag == 0) return r;
    e = maxe;
    if ((mag >> 23) > 1) begin
      mag = mag >> 1;
      e++;
    end else begin
      while ((mag >> 23) == 0) begin
        mag = mag << 1;
        e--;
      end
    end
    r.exponent_wrapped = (e < 0 || e > 255);
    r.result_bits = {sgn, 8'(e), mag[22:0]};
    return r;
  endfunction

  // one transfer; expectation is queued at the accepting edge
  // start stays high so back-to-back transfers follow; callers lower it for gaps
  task automatic send_operands(fadd_in_t x, bit typed_in, fadd_out_t typed);
    start <= 1'b1;
    din   <= x;
    do @(posedge clk); while (busy);
    sum_queue.push_back(typed_in ? typed : float_sum(x));
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] w;
    w = $urandom;
    // bias exponents toward extremes and close values
    case ($urandom_range(0, 5))
      0: w[30:23] = 8'hFF - 8'($urandom_range(0, 2));
      1: w[30:23] = 8'($urandom_range(0, 2));
      2: w[30:23] = 8'd127 + 8'($urandom_range(0, 3));
      default: ;
    endcase
    return w;
  endfunction

  // check results and track progress
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done) begin
        if (sum_queue.size() == 0) begin
          $display("%0t: unexpected result %h/%0b", $time,
                   dout.result_bits, dout.exponent_wrapped);
          error_count++;
        end else begin
          fadd_out_t want;
          want = sum_queue.pop_front();
          if (dout.result_bits !== want.result_bits) begin
            $display("%0t: result_bits expected %h actual %h", $time,
                     want.result_bits, dout.result_bits);
            error_count++;
          end
          if (dout.exponent_wrapped !== want.exponent_wrapped) begin
            $display("%0t: exponent_wrapped expected %0b actual %0b", $time,
                     want.exponent_wrapped, dout.exponent_wrapped);
            error_count++;
          end
        end
      end
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst && idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  typedef struct {
    fadd_in_t  stim;
    bit        typed_in;
    fadd_out_t want;
  } vector_t;

  vector_t vectors[] = '{
    // zero plus zero: hidden ones add, carry out
    '{'{OP_ADD, 32'h0000_0000, 32'h0000_0000}, 1, '{32'h0080_0000, 1'b0}},
    // equal operands subtracted give +0
    '{'{OP_SUB, 32'h3F80_0000, 32'h3F80_0000}, 1, '{32'h0000_0000, 1'b0}},
    '{'{OP_SUB, 32'hC000_0000, 32'hC000_0000}, 1, '{32'h0000_0000, 1'b0}},
    '{'{OP_ADD, 32'h3F80_0000, 32'h3F80_0000}, 1, '{32'h4000_0000, 1'b0}},
    // carry beyond the top exponent wraps
    '{'{OP_ADD, 32'h7F80_0000, 32'h7F80_0000}, 1, '{32'h0000_0000, 1'b1}},
    '{'{OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1, '{32'h807F_FFFF, 1'b1}},
    '{'{OP_SUB, 32'hFFFF_FFFF, 32'h7FFF_FFFF}, 0, '0},
    // tiny differences near exponent zero; the first underflows and wraps
    '{'{OP_SUB, 32'h0000_0001, 32'h0000_0000}, 0, '0},
    '{'{OP_SUB, 32'h0080_0000, 32'h0000_0000}, 0, '0},
    // shift above 23 drops the smaller operand; a shift of exactly 23 keeps it
    '{'{OP_ADD, 32'h4B80_0000, 32'h3F80_0000}, 0, '0},
    '{'{OP_ADD, 32'h4B00_0000, 32'h3F80_0000}, 0, '0},
    '{'{OP_SUB, 32'h3F80_0000, 32'h4000_0000}, 0, '0},
    '{'{OP_ADD, 32'h3F80_0000, 32'hBF7F_FFFF}, 0, '0},
    '{'{OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF}, 0, '0},
    '{'{OP_ADD, 32'h5555_5555, 32'hAAAA_AAAA}, 0, '0},
    '{'{OP_SUB, 32'hAAAA_AAAA, 32'h5555_5555}, 0, '0}
  };

  initial begin
    fadd_in_t x;
    error_count = 0;
    rst   = 1'b1;
    start = 1'b0;
    din   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (vectors[i]) send_operands(vectors[i].stim, vectors[i].typed_in,
                                       vectors[i].want);

    // random operand pairs with random gaps
    for (int n = 0; n < N_RANDOM; n++) begin
      x.op = 1'($urandom);
      x.a_bits = random_operand();
      x.b_bits = ($urandom_range(0, 3) == 0)
               ? (x.a_bits ^ 32'($urandom_range(0, 255)))
               : random_operand();
      send_operands(x, 0, '0);
      if (n == N_RANDOM / 2) begin
        // drain the pipeline once mid-run
        start <= 1'b0;
        while (sum_queue.size() != 0) @(negedge clk);
      end else if (n % 200 >= 100) begin
        // back-to-back stretch
      end else if ($urandom_range(0, 19) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(5, 30)) @(negedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
    end

    start <= 1'b0;
    while (sum_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: float_add_sub_truncating.f
rtl/core/fadd_pkg.sv
rtl/core/fadd_align.sv
rtl/core/fadd_sum.sv
rtl/core/fadd_norm.sv
rtl/core/float_add_sub_truncating.sv
sim/tb.sv
